// ===== hdl/c3wta_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3wta_pkg
// Shared types and constants for the 3D filter transpose address generator.
// ----------------------------------------------------------------------------
package c3wta_pkg;

    // Register file geometry
    localparam int CFG_ADDR_W  = 5;
    localparam int CFG_DATA_W  = 32;
    localparam int CH_SIZE_W   = 11;
    localparam int KER_SIZE_W  = 5;
    localparam int OFFSET_W    = 32;
    localparam int WEIGHT_W    = 16;

    // Register indexes (word address paddr[4:2])
    localparam logic [2:0] REG_OUT_CHANNELS  = 3'd0;
    localparam logic [2:0] REG_IN_CHANNELS   = 3'd1;
    localparam logic [2:0] REG_KERNEL_DEPTH  = 3'd2;
    localparam logic [2:0] REG_KERNEL_HEIGHT = 3'd3;
    localparam logic [2:0] REG_KERNEL_WIDTH  = 3'd4;

    // Effective dimension sizes, after zero and limit handling
    typedef struct packed {
        logic [CH_SIZE_W-1:0]  out_channels;
        logic [CH_SIZE_W-1:0]  in_channels;
        logic [KER_SIZE_W-1:0] kernel_depth;
        logic [KER_SIZE_W-1:0] kernel_height;
        logic [KER_SIZE_W-1:0] kernel_width;
    } sizes_t;

endpackage
`default_nettype wire

// ===== hdl/c3wta_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3wta_regs
// APB register file for the five dimension sizes; derives effective sizes.
// ----------------------------------------------------------------------------
module c3wta_regs #(
    parameter int MAX_CHANNELS = 1024,
    parameter int MAX_KERNEL   = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [c3wta_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [c3wta_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [c3wta_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                     pready,
    output c3wta_pkg::sizes_t                        sizes
);

    logic [c3wta_pkg::CH_SIZE_W-1:0]  out_channels_reg;
    logic [c3wta_pkg::CH_SIZE_W-1:0]  in_channels_reg;
    logic [c3wta_pkg::KER_SIZE_W-1:0] kernel_depth_reg;
    logic [c3wta_pkg::KER_SIZE_W-1:0] kernel_height_reg;
    logic [c3wta_pkg::KER_SIZE_W-1:0] kernel_width_reg;
    logic                             wr_en;
    logic [2:0]                       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];

    // Write the addressed register; drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_channels_reg  <= c3wta_pkg::CH_SIZE_W'(1);
            in_channels_reg   <= c3wta_pkg::CH_SIZE_W'(1);
            kernel_depth_reg  <= c3wta_pkg::KER_SIZE_W'(1);
            kernel_height_reg <= c3wta_pkg::KER_SIZE_W'(1);
            kernel_width_reg  <= c3wta_pkg::KER_SIZE_W'(1);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                c3wta_pkg::REG_OUT_CHANNELS:
                    out_channels_reg  <= pwdata[c3wta_pkg::CH_SIZE_W-1:0];
                c3wta_pkg::REG_IN_CHANNELS:
                    in_channels_reg   <= pwdata[c3wta_pkg::CH_SIZE_W-1:0];
                c3wta_pkg::REG_KERNEL_DEPTH:
                    kernel_depth_reg  <= pwdata[c3wta_pkg::KER_SIZE_W-1:0];
                c3wta_pkg::REG_KERNEL_HEIGHT:
                    kernel_height_reg <= pwdata[c3wta_pkg::KER_SIZE_W-1:0];
                c3wta_pkg::REG_KERNEL_WIDTH:
                    kernel_width_reg  <= pwdata[c3wta_pkg::KER_SIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (reg_idx)
            c3wta_pkg::REG_OUT_CHANNELS:
                prdata = c3wta_pkg::CFG_DATA_W'(out_channels_reg);
            c3wta_pkg::REG_IN_CHANNELS:
                prdata = c3wta_pkg::CFG_DATA_W'(in_channels_reg);
            c3wta_pkg::REG_KERNEL_DEPTH:
                prdata = c3wta_pkg::CFG_DATA_W'(kernel_depth_reg);
            c3wta_pkg::REG_KERNEL_HEIGHT:
                prdata = c3wta_pkg::CFG_DATA_W'(kernel_height_reg);
            c3wta_pkg::REG_KERNEL_WIDTH:
                prdata = c3wta_pkg::CFG_DATA_W'(kernel_width_reg);
            default:
                prdata = '0;
        endcase
    end

    // Zero counts as one; saturate above the limit
    always_comb
    begin
        if (out_channels_reg == '0)
            sizes.out_channels = c3wta_pkg::CH_SIZE_W'(1);
        else if (32'(out_channels_reg) > MAX_CHANNELS)
            sizes.out_channels = c3wta_pkg::CH_SIZE_W'(MAX_CHANNELS);
        else
            sizes.out_channels = out_channels_reg;

        if (in_channels_reg == '0)
            sizes.in_channels = c3wta_pkg::CH_SIZE_W'(1);
        else if (32'(in_channels_reg) > MAX_CHANNELS)
            sizes.in_channels = c3wta_pkg::CH_SIZE_W'(MAX_CHANNELS);
        else
            sizes.in_channels = in_channels_reg;

        if (kernel_depth_reg == '0)
            sizes.kernel_depth = c3wta_pkg::KER_SIZE_W'(1);
        else if (32'(kernel_depth_reg) > MAX_KERNEL)
            sizes.kernel_depth = c3wta_pkg::KER_SIZE_W'(MAX_KERNEL);
        else
            sizes.kernel_depth = kernel_depth_reg;

        if (kernel_height_reg == '0)
            sizes.kernel_height = c3wta_pkg::KER_SIZE_W'(1);
        else if (32'(kernel_height_reg) > MAX_KERNEL)
            sizes.kernel_height = c3wta_pkg::KER_SIZE_W'(MAX_KERNEL);
        else
            sizes.kernel_height = kernel_height_reg;

        if (kernel_width_reg == '0)
            sizes.kernel_width = c3wta_pkg::KER_SIZE_W'(1);
        else if (32'(kernel_width_reg) > MAX_KERNEL)
            sizes.kernel_width = c3wta_pkg::KER_SIZE_W'(MAX_KERNEL);
        else
            sizes.kernel_width = kernel_width_reg;
    end

endmodule
`default_nettype wire

// ===== hdl/c3wta_pos.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3wta_pos
// Five wrapping source position counters, width fastest, out channel slowest.
// ----------------------------------------------------------------------------
module c3wta_pos #(
    parameter int CH_POS_W  = 10,
    parameter int KER_POS_W = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire c3wta_pkg::sizes_t    sizes,
    input  wire logic                 advance,
    output logic [CH_POS_W-1:0]       out_channel_pos,
    output logic [CH_POS_W-1:0]       in_channel_pos,
    output logic [KER_POS_W-1:0]      depth_pos,
    output logic [KER_POS_W-1:0]      height_pos,
    output logic [KER_POS_W-1:0]      width_pos,
    output logic                      last
);

    logic [CH_POS_W-1:0]  oc_pos_reg, oc_pos_next;
    logic [CH_POS_W-1:0]  ic_pos_reg, ic_pos_next;
    logic [KER_POS_W-1:0] d_pos_reg,  d_pos_next;
    logic [KER_POS_W-1:0] h_pos_reg,  h_pos_next;
    logic [KER_POS_W-1:0] w_pos_reg,  w_pos_next;
    logic                 end_w, end_h, end_d, end_i, end_o;

    // Flag each counter at or beyond its final value
    assign end_w = (32'(w_pos_reg)  + 32'd1) >= 32'(sizes.kernel_width);
    assign end_h = (32'(h_pos_reg)  + 32'd1) >= 32'(sizes.kernel_height);
    assign end_d = (32'(d_pos_reg)  + 32'd1) >= 32'(sizes.kernel_depth);
    assign end_i = (32'(ic_pos_reg) + 32'd1) >= 32'(sizes.in_channels);
    assign end_o = (32'(oc_pos_reg) + 32'd1) >= 32'(sizes.out_channels);

    assign last = end_w & end_h & end_d & end_i & end_o;

    // Ripple the carry from width up to out channel
    always_comb
    begin
        oc_pos_next = oc_pos_reg;
        ic_pos_next = ic_pos_reg;
        d_pos_next  = d_pos_reg;
        h_pos_next  = h_pos_reg;
        w_pos_next  = w_pos_reg;
        if (!end_w)
            w_pos_next = w_pos_reg + 1'b1;
        else
        begin
            w_pos_next = '0;
            if (!end_h)
                h_pos_next = h_pos_reg + 1'b1;
            else
            begin
                h_pos_next = '0;
                if (!end_d)
                    d_pos_next = d_pos_reg + 1'b1;
                else
                begin
                    d_pos_next = '0;
                    if (!end_i)
                        ic_pos_next = ic_pos_reg + 1'b1;
                    else
                    begin
                        ic_pos_next = '0;
                        if (!end_o)
                            oc_pos_next = oc_pos_reg + 1'b1;
                        else
                            oc_pos_next = '0;
                    end
                end
            end
        end
    end

    // Advance on every accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oc_pos_reg <= '0;
            ic_pos_reg <= '0;
            d_pos_reg  <= '0;
            h_pos_reg  <= '0;
            w_pos_reg  <= '0;
        end
        else if (advance)
        begin
            oc_pos_reg <= oc_pos_next;
            ic_pos_reg <= ic_pos_next;
            d_pos_reg  <= d_pos_next;
            h_pos_reg  <= h_pos_next;
            w_pos_reg  <= w_pos_next;
        end
    end

    assign out_channel_pos = oc_pos_reg;
    assign in_channel_pos  = ic_pos_reg;
    assign depth_pos       = d_pos_reg;
    assign height_pos      = h_pos_reg;
    assign width_pos       = w_pos_reg;

endmodule
`default_nettype wire

// ===== hdl/c3wta_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3wta_pipe
// Four-stage multiply-add pipeline for the destination offset, with stall.
// ----------------------------------------------------------------------------
module c3wta_pipe #(
    parameter int CH_POS_W  = 10,
    parameter int KER_POS_W = 4,
    parameter int WORD_W    = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire c3wta_pkg::sizes_t                 sizes,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [CH_POS_W-1:0]               out_channel_pos,
    input  wire logic [CH_POS_W-1:0]               in_channel_pos,
    input  wire logic [KER_POS_W-1:0]              depth_pos,
    input  wire logic [KER_POS_W-1:0]              height_pos,
    input  wire logic [KER_POS_W-1:0]              width_pos,
    input  wire logic                              in_last,
    input  wire logic [WORD_W-1:0]                 in_word,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [c3wta_pkg::OFFSET_W-1:0]         out_offset,
    output logic [WORD_W-1:0]                      out_word,
    output logic                                   out_last
);

    localparam int OW = c3wta_pkg::OFFSET_W;

    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic                 rdy1, rdy2, rdy3, rdy4;

    logic [OW-1:0]        acc1_reg, acc2_reg, acc3_reg, acc4_reg;
    logic [KER_POS_W-1:0] h1_reg;
    logic [KER_POS_W-1:0] w1_reg, w2_reg;
    logic [CH_POS_W-1:0]  i1_reg, i2_reg, i3_reg;
    logic [WORD_W-1:0]    wd1_reg, wd2_reg, wd3_reg, wd4_reg;
    logic                 l1_reg, l2_reg, l3_reg, l4_reg;

    // Stall chain: a stage takes new data when empty or when it drains
    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    // Stage 1: depth * OC + out channel
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            acc1_reg <= OW'(depth_pos) * OW'(sizes.out_channels) + OW'(out_channel_pos);
            h1_reg   <= height_pos;
            w1_reg   <= width_pos;
            i1_reg   <= in_channel_pos;
            wd1_reg  <= in_word;
            l1_reg   <= in_last;
        end
    end

    // Stage 2: * KH + height
    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            acc2_reg <= acc1_reg * OW'(sizes.kernel_height) + OW'(h1_reg);
            w2_reg   <= w1_reg;
            i2_reg   <= i1_reg;
            wd2_reg  <= wd1_reg;
            l2_reg   <= l1_reg;
        end
    end

    // Stage 3: * KW + width
    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            acc3_reg <= acc2_reg * OW'(sizes.kernel_width) + OW'(w2_reg);
            i3_reg   <= i2_reg;
            wd3_reg  <= wd2_reg;
            l3_reg   <= l2_reg;
        end
    end

    // Stage 4: * IC + in channel, held as the output register
    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            acc4_reg <= acc3_reg * OW'(sizes.in_channels) + OW'(i3_reg);
            wd4_reg  <= wd3_reg;
            l4_reg   <= l3_reg;
        end
    end

    assign out_valid  = v4_reg;
    assign out_offset = acc4_reg;
    assign out_word   = wd4_reg;
    assign out_last   = l4_reg;

endmodule
`default_nettype wire

// ===== hdl/conv3d_weight_transpose_addr.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conv3d_weight_transpose_addr
// Reorders 3D filter elements from (oc, ic, d, h, w) to (d, oc, h, w, ic).
// ----------------------------------------------------------------------------
// Accepts one filter element per clock cycle unless the output stalls, and
// returns it from the offset pipeline with its element offset in the (depth,
// out channel, height, width, in channel) layout; tlast marks the final
// element of the tensor, after which the position counters restart at zero.
// The offset comes from a multiply-add chain, one multiply per stage, fully
// pipelined, so back-to-back elements flow one per cycle and a stalled output
// fills the stages before s_axis_tready drops. Dimension sizes come from the
// APB registers (0: out_channels, 1: in_channels, 2: kernel_depth,
// 3: kernel_height, 4: kernel_width); zero is taken as one and values above
// the limit saturate. Write them only while no transaction is in flight.
// ----------------------------------------------------------------------------
module conv3d_weight_transpose_addr #(
    parameter int MAX_CHANNELS = 1024,
    parameter int MAX_KERNEL   = 16,
    parameter int DATA_WIDTH   = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // APB configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [c3wta_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [c3wta_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [c3wta_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                     pready,
    // Input stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [15:0]                         s_axis_tdata,  // [15:0] weight_in
    // Output stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [47:0]                              m_axis_tdata,  // [31:0] dest_offset,
                                                                    // [47:32] weight_out
    output logic                                     m_axis_tlast   // last_element
);

    localparam int CH_POS_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int KER_POS_W = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int WORD_W    = (DATA_WIDTH < c3wta_pkg::WEIGHT_W) ?
                               DATA_WIDTH : c3wta_pkg::WEIGHT_W;

    c3wta_pkg::sizes_t          sizes;
    logic [CH_POS_W-1:0]        oc_pos, ic_pos;
    logic [KER_POS_W-1:0]       d_pos, h_pos, w_pos;
    logic                       pos_last;
    logic                       accept;
    logic [c3wta_pkg::OFFSET_W-1:0] offset;
    logic [WORD_W-1:0]          word;

    assign accept = s_axis_tvalid & s_axis_tready;

    // Configuration registers
    c3wta_regs #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_KERNEL   (MAX_KERNEL)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sizes   (sizes)
    );

    // Source position counters
    c3wta_pos #(
        .CH_POS_W  (CH_POS_W),
        .KER_POS_W (KER_POS_W)
    ) u_pos (
        .clk             (clk),
        .rst_n           (rst_n),
        .sizes           (sizes),
        .advance         (accept),
        .out_channel_pos (oc_pos),
        .in_channel_pos  (ic_pos),
        .depth_pos       (d_pos),
        .height_pos      (h_pos),
        .width_pos       (w_pos),
        .last            (pos_last)
    );

    // Offset pipeline
    c3wta_pipe #(
        .CH_POS_W  (CH_POS_W),
        .KER_POS_W (KER_POS_W),
        .WORD_W    (WORD_W)
    ) u_pipe (
        .clk             (clk),
        .rst_n           (rst_n),
        .sizes           (sizes),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .out_channel_pos (oc_pos),
        .in_channel_pos  (ic_pos),
        .depth_pos       (d_pos),
        .height_pos      (h_pos),
        .width_pos       (w_pos),
        .in_last         (pos_last),
        .in_word         (s_axis_tdata[WORD_W-1:0]),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_offset      (offset),
        .out_word        (word),
        .out_last        (m_axis_tlast)
    );

    // Pack the result, zero-filling the weight above DATA_WIDTH
    assign m_axis_tdata = {c3wta_pkg::WEIGHT_W'(word), offset};

endmodule
`default_nettype wire
